[sv/gn3_pkg.sv]
// Constants and tables for 3-D gradient noise.
package gn3_pkg;

    localparam int unsigned CoordWidth = 32;
    localparam int unsigned NoiseWidth = 18;
    localparam int unsigned CellWidth  = 8;

    typedef logic [CellWidth-1:0] t_cell;

    function automatic t_cell perm(input t_cell idx);
        t_cell r;
        case (idx)
            8'd0: r = 8'd151; 8'd1: r = 8'd160; 8'd2: r = 8'd137; 8'd3: r = 8'd91;
            8'd4: r = 8'd90; 8'd5: r = 8'd15; 8'd6: r = 8'd131; 8'd7: r = 8'd13;
            8'd8: r = 8'd201; 8'd9: r = 8'd95; 8'd10: r = 8'd96; 8'd11: r = 8'd53;
            8'd12: r = 8'd194; 8'd13: r = 8'd233; 8'd14: r = 8'd7; 8'd15: r = 8'd225;
            8'd16: r = 8'd140; 8'd17: r = 8'd36; 8'd18: r = 8'd103; 8'd19: r = 8'd30;
            8'd20: r = 8'd69; 8'd21: r = 8'd142; 8'd22: r = 8'd8; 8'd23: r = 8'd99;
            8'd24: r = 8'd37; 8'd25: r = 8'd240; 8'd26: r = 8'd21; 8'd27: r = 8'd10;
            8'd28: r = 8'd23; 8'd29: r = 8'd190; 8'd30: r = 8'd6; 8'd31: r = 8'd148;
            8'd32: r = 8'd247; 8'd33: r = 8'd120; 8'd34: r = 8'd234; 8'd35: r = 8'd75;
            8'd36: r = 8'd0; 8'd37: r = 8'd26; 8'd38: r = 8'd197; 8'd39: r = 8'd62;
            8'd40: r = 8'd94; 8'd41: r = 8'd252; 8'd42: r = 8'd219; 8'd43: r = 8'd203;
            8'd44: r = 8'd117; 8'd45: r = 8'd35; 8'd46: r = 8'd11; 8'd47: r = 8'd32;
            8'd48: r = 8'd57; 8'd49: r = 8'd177; 8'd50: r = 8'd33; 8'd51: r = 8'd88;
            8'd52: r = 8'd237; 8'd53: r = 8'd149; 8'd54: r = 8'd56; 8'd55: r = 8'd87;
            8'd56: r = 8'd174; 8'd57: r = 8'd20; 8'd58: r = 8'd125; 8'd59: r = 8'd136;
            8'd60: r = 8'd171; 8'd61: r = 8'd168; 8'd62: r = 8'd68; 8'd63: r = 8'd175;
            8'd64: r = 8'd74; 8'd65: r = 8'd165; 8'd66: r = 8'd71; 8'd67: r = 8'd134;
            8'd68: r = 8'd139; 8'd69: r = 8'd48; 8'd70: r = 8'd27; 8'd71: r = 8'd166;
            8'd72: r = 8'd77; 8'd73: r = 8'd146; 8'd74: r = 8'd158; 8'd75: r = 8'd231;
            8'd76: r = 8'd83; 8'd77: r = 8'd111; 8'd78: r = 8'd229; 8'd79: r = 8'd122;
            8'd80: r = 8'd60; 8'd81: r = 8'd211; 8'd82: r = 8'd133; 8'd83: r = 8'd230;
            8'd84: r = 8'd220; 8'd85: r = 8'd105; 8'd86: r = 8'd92; 8'd87: r = 8'd41;
            8'd88: r = 8'd55; 8'd89: r = 8'd46; 8'd90: r = 8'd245; 8'd91: r = 8'd40;
            8'd92: r = 8'd244; 8'd93: r = 8'd102; 8'd94: r = 8'd143; 8'd95: r = 8'd54;
            8'd96: r = 8'd65; 8'd97: r = 8'd25; 8'd98: r = 8'd63; 8'd99: r = 8'd161;
            8'd100: r = 8'd1; 8'd101: r = 8'd216; 8'd102: r = 8'd80; 8'd103: r = 8'd73;
            8'd104: r = 8'd209; 8'd105: r = 8'd76; 8'd106: r = 8'd132; 8'd107: r = 8'd187;
            8'd108: r = 8'd208; 8'd109: r = 8'd89; 8'd110: r = 8'd18; 8'd111: r = 8'd169;
            8'd112: r = 8'd200; 8'd113: r = 8'd196; 8'd114: r = 8'd135; 8'd115: r = 8'd130;
            8'd116: r = 8'd116; 8'd117: r = 8'd188; 8'd118: r = 8'd159; 8'd119: r = 8'd86;
            8'd120: r = 8'd164; 8'd121: r = 8'd100; 8'd122: r = 8'd109; 8'd123: r = 8'd198;
            8'd124: r = 8'd173; 8'd125: r = 8'd186; 8'd126: r = 8'd3; 8'd127: r = 8'd64;
            8'd128: r = 8'd52; 8'd129: r = 8'd217; 8'd130: r = 8'd226; 8'd131: r = 8'd250;
            8'd132: r = 8'd124; 8'd133: r = 8'd123; 8'd134: r = 8'd5; 8'd135: r = 8'd202;
            8'd136: r = 8'd38; 8'd137: r = 8'd147; 8'd138: r = 8'd118; 8'd139: r = 8'd126;
            8'd140: r = 8'd255; 8'd141: r = 8'd82; 8'd142: r = 8'd85; 8'd143: r = 8'd212;
            8'd144: r = 8'd207; 8'd145: r = 8'd206; 8'd146: r = 8'd59; 8'd147: r = 8'd227;
            8'd148: r = 8'd47; 8'd149: r = 8'd16; 8'd150: r = 8'd58; 8'd151: r = 8'd17;
            8'd152: r = 8'd182; 8'd153: r = 8'd189; 8'd154: r = 8'd28; 8'd155: r = 8'd42;
            8'd156: r = 8'd223; 8'd157: r = 8'd183; 8'd158: r = 8'd170; 8'd159: r = 8'd213;
            8'd160: r = 8'd119; 8'd161: r = 8'd248; 8'd162: r = 8'd152; 8'd163: r = 8'd2;
            8'd164: r = 8'd44; 8'd165: r = 8'd154; 8'd166: r = 8'd163; 8'd167: r = 8'd70;
            8'd168: r = 8'd221; 8'd169: r = 8'd153; 8'd170: r = 8'd101; 8'd171: r = 8'd155;
            8'd172: r = 8'd167; 8'd173: r = 8'd43; 8'd174: r = 8'd172; 8'd175: r = 8'd9;
            8'd176: r = 8'd129; 8'd177: r = 8'd22; 8'd178: r = 8'd39; 8'd179: r = 8'd253;
            8'd180: r = 8'd19; 8'd181: r = 8'd98; 8'd182: r = 8'd108; 8'd183: r = 8'd110;
            8'd184: r = 8'd79; 8'd185: r = 8'd113; 8'd186: r = 8'd224; 8'd187: r = 8'd232;
            8'd188: r = 8'd178; 8'd189: r = 8'd185; 8'd190: r = 8'd112; 8'd191: r = 8'd104;
            8'd192: r = 8'd218; 8'd193: r = 8'd246; 8'd194: r = 8'd97; 8'd195: r = 8'd228;
            8'd196: r = 8'd251; 8'd197: r = 8'd34; 8'd198: r = 8'd242; 8'd199: r = 8'd193;
            8'd200: r = 8'd238; 8'd201: r = 8'd210; 8'd202: r = 8'd144; 8'd203: r = 8'd12;
            8'd204: r = 8'd191; 8'd205: r = 8'd179; 8'd206: r = 8'd162; 8'd207: r = 8'd241;
            8'd208: r = 8'd81; 8'd209: r = 8'd51; 8'd210: r = 8'd145; 8'd211: r = 8'd235;
            8'd212: r = 8'd249; 8'd213: r = 8'd14; 8'd214: r = 8'd239; 8'd215: r = 8'd107;
            8'd216: r = 8'd49; 8'd217: r = 8'd192; 8'd218: r = 8'd214; 8'd219: r = 8'd31;
            8'd220: r = 8'd181; 8'd221: r = 8'd199; 8'd222: r = 8'd106; 8'd223: r = 8'd157;
            8'd224: r = 8'd184; 8'd225: r = 8'd84; 8'd226: r = 8'd204; 8'd227: r = 8'd176;
            8'd228: r = 8'd115; 8'd229: r = 8'd121; 8'd230: r = 8'd50; 8'd231: r = 8'd45;
            8'd232: r = 8'd127; 8'd233: r = 8'd4; 8'd234: r = 8'd150; 8'd235: r = 8'd254;
            8'd236: r = 8'd138; 8'd237: r = 8'd236; 8'd238: r = 8'd205; 8'd239: r = 8'd93;
            8'd240: r = 8'd222; 8'd241: r = 8'd114; 8'd242: r = 8'd67; 8'd243: r = 8'd29;
            8'd244: r = 8'd24; 8'd245: r = 8'd72; 8'd246: r = 8'd243; 8'd247: r = 8'd141;
            8'd248: r = 8'd128; 8'd249: r = 8'd195; 8'd250: r = 8'd78; 8'd251: r = 8'd66;
            8'd252: r = 8'd215; 8'd253: r = 8'd61; 8'd254: r = 8'd156; default: r = 8'd180;
        endcase
        return r;
    endfunction

    // gradient row sign codes: 2'b01 = +1, 2'b11 = -1, 2'b00 = 0; packed {x,y,z}
    typedef logic [5:0] t_grad;
    localparam t_grad GRAD [16] = '{
        6'b01_01_00, 6'b11_01_00, 6'b01_11_00, 6'b11_11_00,
        6'b01_00_01, 6'b11_00_01, 6'b01_00_11, 6'b11_00_11,
        6'b00_01_01, 6'b00_11_01, 6'b00_01_11, 6'b00_11_11,
        6'b01_00_11, 6'b11_00_11, 6'b00_11_01, 6'b00_01_01};

endpackage

[sv/gn3_rmul.sv]
// Registered signed multiply with round-half-up to FRAC_BITS fractional bits.
module gn3_rmul #(
    parameter int unsigned FRAC_BITS = 16,
    parameter int unsigned AW = 20,
    parameter int unsigned BW = 20,
    parameter int unsigned RW = 24
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic signed [RW-1:0] o_p
);
    localparam int unsigned PW = AW + BW;
    localparam logic signed [PW-1:0] Half = PW'(1) <<< (FRAC_BITS - 1);
    logic signed [PW-1:0] w_prod;
    logic signed [PW-1:0] w_sh;
    logic signed [RW-1:0] r_p;

    assign w_prod = (PW'(i_a) * PW'(i_b)) + Half;
    assign w_sh   = w_prod >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= w_sh[RW-1:0];
        end
    end
    assign o_p = r_p;
endmodule

[sv/gradient_noise_3d.sv]
// 3-D gradient noise: nine-stage pipeline, one transfer per clock unless the output stalls.
// o_valid is the valid bit of the last stage register; a result transfers on a clock
// edge where o_valid and i_ready are both high.
// Throughput: one item per cycle; the pipeline advances whenever the output
// stage is empty or being taken, so a stall holds every stage in place.
// Reset (synchronous, active low) clears all stage valid bits; data regs are not reset.
// Stages: S1 fraction/cell regs; S2 fade step 1 + perm level 1; S2-S5 fade products and
// hash levels and dots; S6-S8 three lerp levels; S9 saturation.
module gradient_noise_3d #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [gn3_pkg::CoordWidth-1:0] i_x_coord,
    input  logic signed [gn3_pkg::CoordWidth-1:0] i_y_coord,
    input  logic signed [gn3_pkg::CoordWidth-1:0] i_z_coord,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [gn3_pkg::NoiseWidth-1:0] o_noise_value
);
    import gn3_pkg::*;

    localparam int unsigned NS = 9;
    // fraction + sign headroom; fade intermediates stay below 16*ONE in magnitude
    localparam int unsigned FW = FRAC_BITS + 6;
    // dots lie in [-2,2]*ONE; lerp values stay similar
    localparam int unsigned DW = FRAC_BITS + 4;
    localparam logic signed [FW-1:0] One = FW'(1) <<< FRAC_BITS;

    logic [NS-1:0] r_v;
    logic          w_en;

    // the whole pipeline advances together; the last stage is the output register
    assign w_en    = !r_v[NS-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    // ---------------- S1: split coordinates
    logic signed [FW-1:0] r1_f [3];
    t_cell                r1_c [3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_f[0] <= FW'({1'b0, i_x_coord[FRAC_BITS-1:0]});
            r1_f[1] <= FW'({1'b0, i_y_coord[FRAC_BITS-1:0]});
            r1_f[2] <= FW'({1'b0, i_z_coord[FRAC_BITS-1:0]});
            r1_c[0] <= i_x_coord[FRAC_BITS +: CellWidth];
            r1_c[1] <= i_y_coord[FRAC_BITS +: CellWidth];
            r1_c[2] <= i_z_coord[FRAC_BITS +: CellWidth];
        end
    end

    // ---------------- fade pipeline per axis; fractions travel alongside
    // S2: p1 = rnd(f*(6f-15)), f2 = rnd(f*f)
    // S3: p2 = rnd(f*(p1+10)), f3 = rnd(f2*f)
    // S4: fade = rnd(f3*p2)
    logic signed [FW-1:0] w_p1 [3], w_f2 [3], w_p2 [3], w_f3 [3], w_fd [3];
    logic signed [FW-1:0] r2_f [3], r3_f [3], r4_f [3];
    logic signed [FW-1:0] r5_fd [3];
    logic signed [FW-1:0] w_a [3], w_b [3];

    for (genvar g = 0; g < 3; g++) begin : g_fade
        assign w_a[g] = FW'(r1_f[g] * 6) - FW'(One * 15);
        gn3_rmul #(.FRAC_BITS(FRAC_BITS), .AW(FW), .BW(FW), .RW(FW)) u_p1 (
            .i_clk(i_clk), .i_en(w_en), .i_a(r1_f[g]), .i_b(w_a[g]), .o_p(w_p1[g]));
        gn3_rmul #(.FRAC_BITS(FRAC_BITS), .AW(FW), .BW(FW), .RW(FW)) u_f2 (
            .i_clk(i_clk), .i_en(w_en), .i_a(r1_f[g]), .i_b(r1_f[g]), .o_p(w_f2[g]));
        assign w_b[g] = w_p1[g] + FW'(One * 10);
        gn3_rmul #(.FRAC_BITS(FRAC_BITS), .AW(FW), .BW(FW), .RW(FW)) u_p2 (
            .i_clk(i_clk), .i_en(w_en), .i_a(r2_f[g]), .i_b(w_b[g]), .o_p(w_p2[g]));
        gn3_rmul #(.FRAC_BITS(FRAC_BITS), .AW(FW), .BW(FW), .RW(FW)) u_f3 (
            .i_clk(i_clk), .i_en(w_en), .i_a(w_f2[g]), .i_b(r2_f[g]), .o_p(w_f3[g]));
        gn3_rmul #(.FRAC_BITS(FRAC_BITS), .AW(FW), .BW(FW), .RW(FW)) u_fd (
            .i_clk(i_clk), .i_en(w_en), .i_a(w_f3[g]), .i_b(w_p2[g]), .o_p(w_fd[g]));
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r2_f[g]  <= r1_f[g];
                r3_f[g]  <= r2_f[g];
                r4_f[g]  <= r3_f[g];
                r5_fd[g] <= w_fd[g];
            end
        end
    end

    // ---------------- hash: one permutation level per stage, S2..S4
    t_cell r2_px [2];
    t_cell r3_py [4];
    t_cell r4_h  [8];
    t_cell r2_c [3], r3_cz;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_px[0] <= perm(r1_c[0]);
            r2_px[1] <= perm(r1_c[0] + 8'd1);
            r2_c     <= r1_c;
            r3_cz    <= r2_c[2];
            for (int j = 0; j < 4; j++) begin
                r3_py[j] <= perm(r2_px[j & 1] + r2_c[1] + t_cell'(j >> 1));
            end
            for (int k = 0; k < 8; k++) begin
                r4_h[k] <= perm(r3_py[k & 3] + r3_cz + t_cell'(k >> 2));
            end
        end
    end

    function automatic logic signed [DW-1:0] term(input logic [1:0] s,
                                                  input logic signed [DW-1:0] d);
        logic signed [DW-1:0] r;
        case (s)
            2'b01:   r = d;
            2'b11:   r = -d;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [DW-1:0] dot_of(input t_grad g,
        input logic signed [DW-1:0] dx, input logic signed [DW-1:0] dy,
        input logic signed [DW-1:0] dz);
        return term(g[5:4], dx) + term(g[3:2], dy) + term(g[1:0], dz);
    endfunction

    // S5: corner dot products
    logic signed [DW-1:0] r5_dot [8];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 8; k++) begin
                r5_dot[k] <= dot_of(GRAD[r4_h[k][3:0]],
                    DW'(r4_f[0]) - ((k & 1) != 0 ? DW'(One) : DW'(0)),
                    DW'(r4_f[1]) - ((k & 2) != 0 ? DW'(One) : DW'(0)),
                    DW'(r4_f[2]) - ((k & 4) != 0 ? DW'(One) : DW'(0)));
            end
        end
    end

    // ---------------- S6..S8: lerp levels along x, y, z
    logic signed [DW-1:0] w_lx [4], w_ly [2], w_lz;
    logic signed [DW-1:0] r6_a [4], r7_a [2], r8_a;
    logic signed [FW-1:0] r6_fd [2], r7_fd;
    logic signed [DW-1:0] w_dx [4], w_dy [2], w_dz;

    for (genvar g = 0; g < 4; g++) begin : g_lx
        assign w_dx[g] = r5_dot[2*g+1] - r5_dot[2*g];
        gn3_rmul #(.FRAC_BITS(FRAC_BITS), .AW(FW), .BW(DW), .RW(DW)) u_m (
            .i_clk(i_clk), .i_en(w_en), .i_a(r5_fd[0]), .i_b(w_dx[g]), .o_p(w_lx[g]));
    end
    for (genvar g = 0; g < 2; g++) begin : g_ly
        assign w_dy[g] = (r6_a[2*g+1] + w_lx[2*g+1]) - (r6_a[2*g] + w_lx[2*g]);
        gn3_rmul #(.FRAC_BITS(FRAC_BITS), .AW(FW), .BW(DW), .RW(DW)) u_m (
            .i_clk(i_clk), .i_en(w_en), .i_a(r6_fd[0]), .i_b(w_dy[g]), .o_p(w_ly[g]));
    end
    assign w_dz = (r7_a[1] + w_ly[1]) - (r7_a[0] + w_ly[0]);
    gn3_rmul #(.FRAC_BITS(FRAC_BITS), .AW(FW), .BW(DW), .RW(DW)) u_mz (
        .i_clk(i_clk), .i_en(w_en), .i_a(r7_fd), .i_b(w_dz), .o_p(w_lz));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) r6_a[k] <= r5_dot[2*k];
            r6_fd[0] <= r5_fd[1];
            r6_fd[1] <= r5_fd[2];
            r7_a[0]  <= r6_a[0] + w_lx[0];
            r7_a[1]  <= r6_a[2] + w_lx[2];
            r7_fd    <= r6_fd[1];
            r8_a     <= r7_a[0] + w_ly[0];
        end
    end

    // ---------------- S9: saturate to the output range
    logic signed [DW-1:0] w_sum;
    logic signed [NoiseWidth-1:0] r_out;
    localparam logic signed [DW-1:0] Hi = DW'((1 << (NoiseWidth - 1)) - 1);
    localparam logic signed [DW-1:0] Lo = -DW'(1 << (NoiseWidth - 1));
    assign w_sum = r8_a + w_lz;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_sum > Hi)      r_out <= Hi[NoiseWidth-1:0];
            else if (w_sum < Lo) r_out <= Lo[NoiseWidth-1:0];
            else                 r_out <= w_sum[NoiseWidth-1:0];
        end
    end
    assign o_noise_value = r_out;

`ifndef SYNTH
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_noise_value))
        else $error("output changed while stalled");
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("ready low with empty output stage");
    a_vld_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && r_v[NS-2] |=> o_valid)
        else $error("valid lost in pipeline");
`endif
endmodule

[dv/gradient_noise_3d_chk.sv]
// Checker for gradient_noise_3d: predicts each noise value and compares it.
module gradient_noise_3d_chk (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic                                  i_ready_in,
    input  logic signed [gn3_pkg::CoordWidth-1:0] i_x_coord,
    input  logic signed [gn3_pkg::CoordWidth-1:0] i_y_coord,
    input  logic signed [gn3_pkg::CoordWidth-1:0] i_z_coord,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_ready,
    input  logic signed [gn3_pkg::NoiseWidth-1:0] i_noise_value,
    output int                                    o_fail_count,
    output int                                    o_pending
);
    import gn3_pkg::*;

    localparam int Frac = 16;
    localparam longint One = longint'(1) << Frac;

    logic signed [NoiseWidth-1:0] noise_q[$];
    int                           fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = noise_q.size();

    // round half up; >>> on a longint is an arithmetic (floor) shift
    function automatic longint mul_rnd(input longint a, input longint b);
        return (a * b + (One >>> 1)) >>> Frac;
    endfunction

    function automatic longint fade(input longint f);
        longint a, b, c, f2, f3;
        a  = 6 * f - 15 * One;
        b  = mul_rnd(f, a) + 10 * One;
        c  = mul_rnd(f, b);
        f2 = mul_rnd(f, f);
        f3 = mul_rnd(f2, f);
        return mul_rnd(f3, c);
    endfunction

    function automatic longint lerp(input longint t, input longint a, input longint b);
        return a + mul_rnd(t, b - a);
    endfunction

    // gradient sign code to -1/0/+1
    function automatic longint gsign(input logic [1:0] code);
        return (code == 2'b01) ? 1 : (code == 2'b11) ? -1 : 0;
    endfunction

    function automatic logic signed [NoiseWidth-1:0] noise_at(input logic [31:0] crd[3]);
        t_cell  lat[3];
        longint fr[3], fd[3], off[3], dot[8], v;
        t_cell  cx, cy, cz, h;
        t_grad  g;
        for (int i = 0; i < 3; i++) begin
            lat[i] = crd[i][Frac +: CellWidth];
            fr[i]  = longint'(crd[i][Frac-1:0]);
            fd[i]  = fade(fr[i]);
        end
        for (int c = 0; c < 8; c++) begin
            cx = lat[0] + t_cell'(c & 1);
            cy = lat[1] + t_cell'((c >> 1) & 1);
            cz = lat[2] + t_cell'((c >> 2) & 1);
            h  = perm(perm(perm(cx) + cy) + cz);
            g  = GRAD[h[3:0]];
            for (int i = 0; i < 3; i++)
                off[i] = ((c >> i) & 1) ? fr[i] - One : fr[i];
            dot[c] = gsign(g[5:4]) * off[0] + gsign(g[3:2]) * off[1] + gsign(g[1:0]) * off[2];
        end
        v = lerp(fd[2],
                 lerp(fd[1], lerp(fd[0], dot[0], dot[1]), lerp(fd[0], dot[2], dot[3])),
                 lerp(fd[1], lerp(fd[0], dot[4], dot[5]), lerp(fd[0], dot[6], dot[7])));
        if (v > 131071)  v = 131071;
        if (v < -131072) v = -131072;
        return v[NoiseWidth-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        logic [31:0] crd[3];
        logic signed [NoiseWidth-1:0] want;
        if (i_rst_n) begin
            if (i_valid && i_ready_in) begin
                crd[0] = i_x_coord; crd[1] = i_y_coord; crd[2] = i_z_coord;
                noise_q.push_back(noise_at(crd));
            end
            if (i_out_valid && i_out_ready) begin
                if (noise_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected noise %0d", i_noise_value));
                end else begin
                    want = noise_q.pop_front();
                    if (i_noise_value !== want)
                        report_mismatch($sformatf("noise %0d, want %0d",
                                                  i_noise_value, want));
                end
            end
        end
    end
endmodule

[dv/gradient_noise_3d_tb.sv]
// Testbench top for gradient_noise_3d: stimulus, idling and verdict.
module gradient_noise_3d_tb;
    import gn3_pkg::*;

    logic                         clk = 0;
    logic                         rst_n = 0;
    logic                         in_valid = 0;
    logic                         in_ready;
    logic signed [CoordWidth-1:0] x_coord = '0, y_coord = '0, z_coord = '0;
    logic                         out_valid;
    logic                         out_ready = 0;
    logic signed [NoiseWidth-1:0] noise_value;
    int                           fail_count, pending;
    int                           send_idle_pct = 31, recv_idle_pct = 53;

    always #5 clk = ~clk;

    gradient_noise_3d u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_x_coord(x_coord), .i_y_coord(y_coord), .i_z_coord(z_coord),
        .o_valid(out_valid), .i_ready(out_ready), .o_noise_value(noise_value)
    );

    gradient_noise_3d_chk u_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_ready_in(in_ready),
        .i_x_coord(x_coord), .i_y_coord(y_coord), .i_z_coord(z_coord),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_noise_value(noise_value),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stalls, redrawn every falling edge
    always @(negedge clk)
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    // present one point; valid holds until the transfer
    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        x_coord  <= x;
        y_coord  <= y;
        z_coord  <= z;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // random coordinate: mostly small magnitudes, sometimes full range
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return {{8{1'b0}}, 24'($urandom)} - 32'h0080_0000;
            2:       return {16'($urandom_range(255)), 16'h0} | 32'($urandom_range(3));
            default: return {16'($urandom_range(255)), 16'($urandom)};
        endcase
    endfunction

    initial begin
        logic [31:0] edges[8];
        edges = '{32'h0, 32'h0000_FFFF, 32'h0001_0000, 32'hFFFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h00FF_8000, 32'hFF00_0001};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // field extremes, negative floors, cell wrap at 255
        for (int i = 0; i < 8; i++) send_point(edges[i], edges[(i+3)%8], edges[(i+5)%8]);
        for (int i = 0; i < 8; i++) send_point(edges[i], edges[i], edges[i]);
        send_point(32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF);
        send_point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        send_point(32'hFFFF_8000, 32'h0000_4000, 32'hFFFF_C000);
        // random phases: receiver-heavy idling, sender-heavy, then none
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 53 : 0;
            recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 31 : 0;
            for (int n = 0; n < 480; n++) send_point(rand_coord(), rand_coord(), rand_coord());
        end
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("[gradient_noise_3d] OK");
        else
            $display("[gradient_noise_3d] ERROR");
        $finish;
    end

    initial begin
        #400000;
        $display("[gradient_noise_3d] ERROR");
        $finish;
    end
endmodule
